// ----- design/wja_pkg.sv -----
`timescale 1ns / 1ps

package wja_pkg;

	localparam int TABLE_DEPTH = 1024;
	localparam int ADDR_W      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int FILL_W      = $clog2(TABLE_DEPTH + 1);
	localparam int CNT_W       = 11;
	localparam int SUM_W       = 64 + FILL_W;
	localparam int STEP_W      = $clog2(SUM_W + 1);
	localparam int ENTRY_W     = 64 + 63 + 64;

	localparam logic signed [63:0] I64_HIGHEST = 64'sh7FFF_FFFF_FFFF_FFFF;
	localparam logic signed [63:0] I64_LOWEST  = 64'sh8000_0000_0000_0000;

	typedef enum logic [1:0] {
		OP_CLEAR = 2'd0,
		OP_LOAD  = 2'd1,
		OP_PROBE = 2'd2
	} op_t;

	localparam logic [2:0] AGG_COUNT = 3'd0;
	localparam logic [2:0] AGG_SUM   = 3'd1;
	localparam logic [2:0] AGG_AVG   = 3'd2;
	localparam logic [2:0] AGG_MIN   = 3'd3;
	localparam logic [2:0] AGG_MAX   = 3'd4;

	localparam logic [1:0] REG_BEFORE = 2'd0;
	localparam logic [1:0] REG_AFTER  = 2'd1;
	localparam logic [1:0] REG_MODE   = 2'd2;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DIV,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage

// ----- design/window_join_aggregate_unit.sv -----
`timescale 1ns / 1ps

// Window join with time-range aggregate.
// Input stream s_*: one beat per operation (clear, load right row, probe).
// Clear and load complete without leaving the idle state; loads past the table
// capacity are dropped and raise the overflowed flag until the next clear.
// A probe scans the stored rows one per cycle out of a synchronous row memory
// with a three-stage read/compare/accumulate pipe; average mode then adds a
// bit-serial divide when the hit count is not zero.
// Output stream m_*: one beat per probe, held in an output register; the next
// beat is taken on s_* while that result waits. A probe whose result is done
// waits until the output register is free, and s_tready stays low meanwhile.
// Config port: cfg_we/cfg_index/cfg_data, written by the user only while the block
// is idle; the block itself does not enforce it. Reset empties the table, zeroes
// the probe counter, drop flag and config. Rows stored in memory are not cleared;
// only entries below the fill count are ever read.
module window_join_aggregate_unit (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [199:0] s_tdata,   // operation, row_key, row_time, row_value, zero pad
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [111:0] m_tdata,   // left_row, agg_value, hit count, overflowed, zero pad
	input  logic         cfg_we,
	input  logic [1:0]   cfg_index,
	input  logic [61:0]  cfg_data
);

	localparam int AW = wja_pkg::ADDR_W;
	localparam int FW = wja_pkg::FILL_W;
	localparam int SW = wja_pkg::SUM_W;

	logic [1:0]         in_op;
	logic [63:0]        in_key;
	logic signed [62:0] in_time;
	logic [63:0]        in_value;
	logic signed [63:0] in_time64;

	assign in_op     = s_tdata[1:0];
	assign in_key    = s_tdata[65:2];
	assign in_time   = s_tdata[128:66];
	assign in_value  = s_tdata[192:129];
	assign in_time64 = 64'(in_time);

	logic [61:0] before_q, after_q;
	logic [2:0]  mode_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			before_q <= '0;
			after_q  <= '0;
			mode_q   <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				wja_pkg::REG_BEFORE: before_q <= cfg_data;
				wja_pkg::REG_AFTER:  after_q  <= cfg_data;
				wja_pkg::REG_MODE:   mode_q   <= cfg_data[2:0];
				default: ;
			endcase
		end
	end

	wja_pkg::state_t state_q, state_d;
	logic accept, issue, scan_done, div_start, load_out, out_free;
	logic [FW-1:0] fill_q;
	logic [FW-1:0] rd_addr_q;
	logic [31:0]   probe_q;
	logic          drop_q;
	logic          v_s1, v_s2;

	assign s_tready = (state_q == wja_pkg::ST_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign out_free = !m_tvalid || m_tready;
	assign issue    = (state_q == wja_pkg::ST_SCAN) && (rd_addr_q < fill_q);

	wja_pkg::div_stat_t div_stat;
	logic [63:0]        div_quot;

	logic [FW-1:0]        cnt_q;
	logic signed [SW-1:0] sum_q;
	logic signed [63:0]   min_q, max_q;

	always_comb begin
		state_d   = state_q;
		scan_done = 1'b0;
		div_start = 1'b0;
		load_out  = 1'b0;
		case (state_q)
			wja_pkg::ST_IDLE: begin
				if (accept && in_op == wja_pkg::OP_PROBE)
					state_d = wja_pkg::ST_SCAN;
			end
			wja_pkg::ST_SCAN: begin
				scan_done = !issue && !v_s1 && !v_s2;
				if (scan_done) begin
					if (mode_q == wja_pkg::AGG_AVG && cnt_q != '0) begin
						div_start = 1'b1;
						state_d   = wja_pkg::ST_DIV;
					end else begin
						state_d = wja_pkg::ST_FINISH;
					end
				end
			end
			wja_pkg::ST_DIV: begin
				if (div_stat.done)
					state_d = wja_pkg::ST_FINISH;
			end
			wja_pkg::ST_FINISH: begin
				if (out_free) begin
					load_out = 1'b1;
					state_d  = wja_pkg::ST_IDLE;
				end
			end
			default: state_d = wja_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= wja_pkg::ST_IDLE;
			fill_q  <= '0;
			probe_q <= '0;
			drop_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				case (in_op)
					wja_pkg::OP_CLEAR: begin
						fill_q  <= '0;
						probe_q <= '0;
						drop_q  <= 1'b0;
					end
					wja_pkg::OP_LOAD: begin
						if (fill_q < FW'(wja_pkg::TABLE_DEPTH))
							fill_q <= fill_q + 1'b1;
						else
							drop_q <= 1'b1;
					end
					wja_pkg::OP_PROBE: probe_q <= probe_q + 32'd1;
					default: ;
				endcase
			end
		end
	end

	// row memory: {value, time, key}
	logic [wja_pkg::ENTRY_W-1:0] mem_q [wja_pkg::TABLE_DEPTH];
	logic [wja_pkg::ENTRY_W-1:0] rd_data_s1;

	always_ff @(posedge clk) begin
		if (accept && in_op == wja_pkg::OP_LOAD && fill_q < FW'(wja_pkg::TABLE_DEPTH))
			mem_q[fill_q[AW-1:0]] <= {in_value, in_time, in_key};
		if (issue)
			rd_data_s1 <= mem_q[rd_addr_q[AW-1:0]];
	end

	// probe context
	logic [63:0]        key_q;
	logic signed [63:0] lo_q, hi_q;
	logic [31:0]        row_q;
	logic               ovf_q;

	always_ff @(posedge clk) begin
		if (accept && in_op == wja_pkg::OP_PROBE) begin
			key_q <= in_key;
			lo_q  <= in_time64 - $signed({2'b00, before_q});
			hi_q  <= in_time64 + $signed({2'b00, after_q});
			row_q <= probe_q;
			ovf_q <= drop_q;
		end
	end

	logic [63:0]        rd_key_s1;
	logic signed [63:0] rd_time_s1;
	logic               match_s2;
	logic signed [63:0] value_s2;

	assign rd_key_s1  = rd_data_s1[63:0];
	assign rd_time_s1 = 64'(signed'(rd_data_s1[126:64]));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1      <= 1'b0;
			v_s2      <= 1'b0;
			rd_addr_q <= '0;
		end else begin
			v_s1 <= issue;
			v_s2 <= v_s1;
			if (accept)
				rd_addr_q <= '0;
			else if (issue)
				rd_addr_q <= rd_addr_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		match_s2 <= (rd_key_s1 == key_q) && (rd_time_s1 >= lo_q) && (rd_time_s1 <= hi_q);
		value_s2 <= rd_data_s1[190:127];
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cnt_q <= '0;
			sum_q <= '0;
			min_q <= wja_pkg::I64_HIGHEST;
			max_q <= wja_pkg::I64_LOWEST;
		end else if (v_s2 && match_s2) begin
			cnt_q <= cnt_q + 1'b1;
			sum_q <= sum_q + SW'(value_s2);
			if (value_s2 < min_q)
				min_q <= value_s2;
			if (value_s2 > max_q)
				max_q <= value_s2;
		end
	end

	wja_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (sum_q),
		.divisor  (cnt_q),
		.stat     (div_stat),
		.quotient (div_quot)
	);

	logic [63:0] agg;

	always_comb begin
		agg = '0;
		if (cnt_q != '0) begin
			case (mode_q)
				wja_pkg::AGG_COUNT: agg = 64'(cnt_q);
				wja_pkg::AGG_SUM:   agg = sum_q[63:0];
				wja_pkg::AGG_AVG:   agg = div_quot;
				wja_pkg::AGG_MIN:   agg = (min_q == wja_pkg::I64_HIGHEST) ? '0 : min_q;
				wja_pkg::AGG_MAX:   agg = (max_q == wja_pkg::I64_LOWEST) ? '0 : max_q;
				default:            agg = '0;
			endcase
		end
	end

	logic        out_valid_q;
	logic [31:0] out_row_q;
	logic [63:0] out_agg_q;
	logic [10:0] out_cnt_q;
	logic        out_ovf_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (load_out)
			out_valid_q <= 1'b1;
		else if (m_tready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_row_q <= row_q;
			out_agg_q <= agg;
			out_cnt_q <= wja_pkg::CNT_W'(cnt_q);
			out_ovf_q <= ovf_q;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {4'b0000, out_ovf_q, out_cnt_q, out_agg_q, out_row_q};

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FW'(wja_pkg::TABLE_DEPTH))
		else $error("fill count past table depth");
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == wja_pkg::ST_FINISH |-> cnt_q <= fill_q)
		else $error("more matches than stored rows");
	a_pipe_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 |-> state_q == wja_pkg::ST_SCAN)
		else $error("scan pipe active outside scan");
	a_div_in_state: assert property (@(posedge clk) disable iff (!arst_n)
		div_stat.busy |-> state_q == wja_pkg::ST_DIV)
		else $error("divider running outside divide state");

endmodule

// ----- design/wja_div.sv -----
`timescale 1ns / 1ps

// Signed sum / unsigned count, truncating toward zero; one quotient bit per cycle.
module wja_div (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	input  logic signed [wja_pkg::SUM_W-1:0] dividend,
	input  logic        [wja_pkg::FILL_W-1:0] divisor,
	output wja_pkg::div_stat_t               stat,
	output logic        [63:0]               quotient
);

	logic [wja_pkg::SUM_W-1:0]  dvd_q;
	logic [wja_pkg::FILL_W-1:0] rem_q;
	logic [wja_pkg::FILL_W-1:0] dsr_q;
	logic [wja_pkg::STEP_W-1:0] step_q;
	logic                       neg_q;
	logic                       busy_q;
	logic                       done_q;
	logic [wja_pkg::FILL_W:0]   trial;
	logic                       fits;
	logic [wja_pkg::SUM_W-1:0]  mag;

	assign mag   = dividend[wja_pkg::SUM_W-1] ? (~dividend + 1'b1) : dividend;
	assign trial = {rem_q, dvd_q[wja_pkg::SUM_W-1]};
	assign fits  = trial >= {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= wja_pkg::STEP_W'(wja_pkg::SUM_W);
			end else if (busy_q) begin
				step_q <= step_q - 1'b1;
				if (step_q == wja_pkg::STEP_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= mag;
			rem_q <= '0;
			dsr_q <= divisor;
			neg_q <= dividend[wja_pkg::SUM_W-1];
		end else if (busy_q) begin
			rem_q <= fits ? wja_pkg::FILL_W'(trial - {1'b0, dsr_q})
			              : wja_pkg::FILL_W'(trial);
			dvd_q <= {dvd_q[wja_pkg::SUM_W-2:0], fits};
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign quotient  = neg_q ? (~dvd_q[63:0] + 64'd1) : dvd_q[63:0];

	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(busy_q))
		else $error("divider done without a run");
	a_no_restart: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> !start)
		else $error("divider restarted while busy");
	a_rem_below_divisor: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q && !start |-> rem_q < dsr_q)
		else $error("partial remainder not below divisor");

endmodule

// ----- test/window_join_aggregate_checker.sv -----
`timescale 1ns / 1ps

module window_join_aggregate_checker (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	input  logic         s_tready,
	input  logic [199:0] s_tdata,
	input  logic         m_tvalid,
	input  logic         m_tready,
	input  logic [111:0] m_tdata,
	input  logic         cfg_we,
	input  logic [1:0]   cfg_index,
	input  logic [61:0]  cfg_data,
	output int           errors,
	output int           outstanding
);

	typedef struct packed {
		logic [31:0] left_row;
		logic [63:0] agg_value;
		logic [10:0] hit_count;
		logic        overflowed;
	} join_result_t;

	join_result_t pending_results[$];

	logic [63:0] row_keys[wja_pkg::TABLE_DEPTH];
	longint      row_times[wja_pkg::TABLE_DEPTH];
	logic [63:0] row_values[wja_pkg::TABLE_DEPTH];
	int          rows_held;
	logic [31:0] probe_seq;
	logic        rows_dropped;
	logic [61:0] span_before;
	logic [61:0] span_after;
	logic [2:0]  agg_sel;

	assign outstanding = pending_results.size();

	function automatic join_result_t join_probe(logic [63:0] key, longint t);
		join_result_t r;
		longint lo_t, hi_t, mn, mx, sv;
		logic signed [127:0] total, quot, divisor;
		int n;
		lo_t = t - longint'({2'b00, span_before});
		hi_t = t + longint'({2'b00, span_after});
		mn = wja_pkg::I64_HIGHEST;
		mx = wja_pkg::I64_LOWEST;
		total = '0;
		n = 0;
		for (int i = 0; i < rows_held; i++) begin
			if (row_keys[i] == key && row_times[i] >= lo_t && row_times[i] <= hi_t) begin
				sv = longint'(row_values[i]);
				n++;
				total += sv;
				if (sv < mn) mn = sv;
				if (sv > mx) mx = sv;
			end
		end
		r.left_row = probe_seq;
		r.hit_count = n[10:0];
		r.overflowed = rows_dropped;
		r.agg_value = '0;
		if (n > 0) begin
			case (agg_sel)
				wja_pkg::AGG_COUNT: r.agg_value = 64'(n);
				wja_pkg::AGG_SUM: r.agg_value = total[63:0];
				wja_pkg::AGG_AVG: begin
					divisor = n;
					quot = total / divisor;   // truncates toward zero
					r.agg_value = quot[63:0];
				end
				wja_pkg::AGG_MIN: r.agg_value = (mn == wja_pkg::I64_HIGHEST) ? 64'd0 : mn;
				wja_pkg::AGG_MAX: r.agg_value = (mx == wja_pkg::I64_LOWEST) ? 64'd0 : mx;
				default: r.agg_value = '0;
			endcase
		end
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		join_result_t want, got;
		if (!arst_n) begin
			rows_held    <= 0;
			probe_seq    <= '0;
			rows_dropped <= 1'b0;
			span_before  <= '0;
			span_after   <= '0;
			agg_sel      <= wja_pkg::AGG_COUNT;
			errors       <= 0;
			pending_results.delete();
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					wja_pkg::REG_BEFORE: span_before <= cfg_data;
					wja_pkg::REG_AFTER:  span_after  <= cfg_data;
					wja_pkg::REG_MODE:   agg_sel     <= cfg_data[2:0];
					default: ;
				endcase
			end
			if (m_tvalid && m_tready) begin
				got = {m_tdata[31:0], m_tdata[95:32], m_tdata[106:96], m_tdata[107]};
				if (pending_results.size() == 0) begin
					errors <= errors + 1;
					if (errors < 10)
						$display("%0t: unexpected result beat %h", $realtime, got);
				end else begin
					want = pending_results.pop_front();
					if (want !== got) begin
						errors <= errors + 1;
						if (errors < 10)
							$display("%0t: mismatch row exp %0d/%h/%0d/%b got %0d/%h/%0d/%b",
								$realtime, want.left_row, want.agg_value, want.hit_count,
								want.overflowed, got.left_row, got.agg_value,
								got.hit_count, got.overflowed);
					end
				end
			end
			if (s_tvalid && s_tready) begin
				case (wja_pkg::op_t'(s_tdata[1:0]))
					wja_pkg::OP_CLEAR: begin
						rows_held    <= 0;
						probe_seq    <= '0;
						rows_dropped <= 1'b0;
					end
					wja_pkg::OP_LOAD: begin
						if (rows_held < wja_pkg::TABLE_DEPTH) begin
							row_keys[rows_held]   <= s_tdata[65:2];
							row_times[rows_held]  <= longint'($signed(s_tdata[128:66]));
							row_values[rows_held] <= s_tdata[192:129];
							rows_held <= rows_held + 1;
						end else begin
							rows_dropped <= 1'b1;
						end
					end
					wja_pkg::OP_PROBE: begin
						pending_results.insert(pending_results.size(),
							join_probe(s_tdata[65:2], longint'($signed(s_tdata[128:66]))));
						probe_seq <= probe_seq + 1;
					end
					default: ;
				endcase
			end
		end
	end

endmodule

// ----- test/window_join_aggregate_unit_tb.sv -----
`timescale 1ns / 1ps

module window_join_aggregate_unit_tb;

	localparam logic [61:0] SPAN_MAX = {62{1'b1}};
	localparam logic signed [62:0] T_MIN = {1'b1, 62'd0};
	localparam logic signed [62:0] T_MAX = {1'b0, {62{1'b1}}};

	logic         clk;
	logic         arst_n;
	logic         s_tvalid;
	logic         s_tready;
	logic [199:0] s_tdata;
	logic         m_tvalid;
	logic         m_tready;
	logic [111:0] m_tdata;
	logic         cfg_we;
	logic [1:0]   cfg_index;
	logic [61:0]  cfg_data;
	int           errors;
	int           outstanding;

	int send_idle_pct;
	int recv_idle_pct;
	int hold_requests;
	int hold_served;
	int item_total;
	logic [63:0] key_pool[4];
	logic signed [62:0] time_base;

	window_join_aggregate_unit dut (.*);

	window_join_aggregate_checker chk (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#200_000_000;
		$display("window_join_aggregate_unit_tb: errors");
		$finish;
	end

	// receiver: random backpressure plus occasional long hold-off
	initial begin
		int hold_left;
		m_tready = 1'b0;
		hold_served = 0;
		hold_left = 0;
		forever begin
			@(negedge clk);
			if (hold_left == 0 && hold_served < hold_requests) begin
				hold_served++;
				hold_left = 3000;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	// called at a falling edge; returns at a falling edge
	task automatic send_beat(wja_pkg::op_t op, logic [63:0] key, logic signed [62:0] t,
			logic [63:0] val);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {7'd0, val, t, key, op};
		do @(posedge clk); while (!s_tready);
		item_total++;
		@(negedge clk);
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (outstanding != 0) @(negedge clk);
		repeat (20) @(negedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [61:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	function automatic logic [61:0] pick_span();
		case ($urandom_range(9))
			0: return '0;
			1: return SPAN_MAX;
			2: return 62'(rand64());
			default: return 62'($urandom_range(40));
		endcase
	endfunction

	function automatic logic [63:0] pick_key();
		return ($urandom_range(19) == 0) ? rand64() : key_pool[$urandom_range(3)];
	endfunction

	function automatic logic signed [62:0] pick_time();
		return ($urandom_range(19) == 0) ? 63'(rand64())
		                                 : time_base + 63'($urandom_range(60));
	endfunction

	function automatic logic [63:0] pick_value();
		case ($urandom_range(3))
			0: return rand64();
			1: return $urandom_range(1) ? 64'h7FFF_FFFF_FFFF_FFFF : 64'h8000_0000_0000_0000;
			default: return 64'(longint'($urandom_range(200)) - 100);
		endcase
	endfunction

	task automatic new_setting();
		logic [2:0] m;
		wait_drained();
		m = ($urandom_range(9) == 0) ? 3'($urandom_range(5, 7)) : 3'($urandom_range(4));
		write_reg(wja_pkg::REG_BEFORE, pick_span());
		write_reg(wja_pkg::REG_AFTER, pick_span());
		write_reg(wja_pkg::REG_MODE,
			62'({$urandom, $urandom} & 62'h3FFF_FFFF_FFFF_FFF8 | m));
		for (int i = 0; i < 4; i++)
			key_pool[i] = $urandom_range(1) ? rand64() : 64'($urandom_range(3));
		case ($urandom_range(3))
			0: time_base = T_MIN;
			1: time_base = T_MAX - 60;
			default: time_base = 63'(rand64());
		endcase
		if (time_base > T_MAX - 60) time_base = T_MAX - 60;
	endtask

	task automatic run_phase(int n_items, bit with_hold);
		int stop_at;
		stop_at = item_total + n_items;
		while (item_total < stop_at) begin
			if ($urandom_range(39) == 0) new_setting();
			if (with_hold && item_total == stop_at - n_items / 2) hold_requests++;
			case ($urandom_range(99)) inside
				[0:39]:  send_beat(wja_pkg::OP_LOAD, pick_key(), pick_time(), pick_value());
				[40:89]: send_beat(wja_pkg::OP_PROBE, pick_key(), pick_time(), rand64());
				[90:95]: send_beat(wja_pkg::OP_CLEAR, rand64(), 63'(rand64()), rand64());
				default: send_beat(wja_pkg::op_t'(2'd3), rand64(), 63'(rand64()), rand64());
			endcase
		end
	endtask

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		hold_requests = 0;
		item_total = 0;
		time_base = '0;
		for (int i = 0; i < 4; i++) key_pool[i] = 64'(i);
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed: extremes, sentinels, empty table, unused op, every mode
		send_beat(wja_pkg::OP_PROBE, 64'd1, 63'sd10, '0);
		send_beat(wja_pkg::OP_LOAD, 64'h8000_0000_0000_0000, T_MIN, 64'h7FFF_FFFF_FFFF_FFFF);
		send_beat(wja_pkg::OP_LOAD, 64'h7FFF_FFFF_FFFF_FFFF, T_MAX, 64'h8000_0000_0000_0000);
		send_beat(wja_pkg::OP_LOAD, 64'd1, 63'sd10, -64'sd7);
		send_beat(wja_pkg::OP_LOAD, 64'd1, 63'sd12, 64'sd3);
		send_beat(wja_pkg::OP_LOAD, 64'd1, 63'sd20, 64'sd5);
		send_beat(wja_pkg::op_t'(2'd3), '1, T_MAX, '1);
		send_beat(wja_pkg::OP_PROBE, 64'h8000_0000_0000_0000, T_MIN, '0);
		send_beat(wja_pkg::OP_PROBE, 64'd1, 63'sd12, '0);
		wait_drained();
		write_reg(wja_pkg::REG_BEFORE, SPAN_MAX);
		write_reg(wja_pkg::REG_AFTER, SPAN_MAX);
		for (int m = 0; m < 8; m++) begin
			wait_drained();
			write_reg(wja_pkg::REG_MODE, 62'(m));
			send_beat(wja_pkg::OP_PROBE, 64'd1, T_MAX, '0);
			send_beat(wja_pkg::OP_PROBE, 64'h8000_0000_0000_0000, T_MAX, '0);
			send_beat(wja_pkg::OP_PROBE, 64'h7FFF_FFFF_FFFF_FFFF, T_MIN, '0);
		end
		wait_drained();
		write_reg(wja_pkg::REG_AFTER, '0);
		send_beat(wja_pkg::OP_PROBE, 64'd1, 63'sd19, '0);
		send_beat(wja_pkg::OP_CLEAR, '0, '0, '0);

		send_idle_pct = 15;
		recv_idle_pct = 80;
		new_setting();
		run_phase(180, 1'b1);
		send_idle_pct = 80;
		recv_idle_pct = 15;
		new_setting();
		run_phase(180, 1'b0);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		new_setting();
		run_phase(180, 1'b1);

		// fill the table past capacity, probe four times, then load once more and probe
		new_setting();
		send_beat(wja_pkg::OP_CLEAR, '0, '0, '0);
		for (int i = 0; i < wja_pkg::TABLE_DEPTH + 3; i++)
			send_beat(wja_pkg::OP_LOAD, pick_key(), pick_time(), pick_value());
		repeat (4) send_beat(wja_pkg::OP_PROBE, pick_key(), pick_time(), '0);
		send_beat(wja_pkg::OP_LOAD, pick_key(), pick_time(), pick_value());
		send_beat(wja_pkg::OP_PROBE, pick_key(), pick_time(), '0);

		wait_drained();
		repeat (100) @(negedge clk);
		if (errors == 0)
			$display("window_join_aggregate_unit_tb: clean");
		else
			$display("window_join_aggregate_unit_tb: errors");
		$finish;
	end

endmodule
